[hdl/bdch_pkg.sv]
`default_nettype none
package bdch_pkg;

	localparam int FUNC_W  = 2;
	localparam int TIME_W  = 32;
	localparam int RAW_W   = 4;
	localparam int BTN_W   = 2;
	localparam int DELAY_W = 15;
	localparam int CFG_W   = 16;
	localparam int MASK_W  = 4;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
	localparam logic [CFG_W-1:0] CLICK_RESET    = CFG_W'(300);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_POLL  = 2'd0,
		FUNC_HOLD  = 2'd1,
		FUNC_CLICK = 2'd2
	} func_t;

	// register index as seen in paddr[2]
	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_CLICK    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic do_poll;
		logic do_hold;
		logic do_click;
	} lane_cmd_t;

	typedef struct packed {
		logic level;
		logic held;
		logic clicked;
	} lane_res_t;

	typedef struct packed {
		logic [MASK_W-1:0] pressed_mask;
		logic              held;
		logic              clicked;
	} result_t;

endpackage
`default_nettype wire

[hdl/bdch_in_if.sv]
`default_nettype none
interface bdch_in_if
	import bdch_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [TIME_W-1:0]  now_ms;
	logic [RAW_W-1:0]   raw_levels;
	logic [BTN_W-1:0]   button;
	logic [DELAY_W-1:0] hold_delay_ms;

	modport source (output valid, func, now_ms, raw_levels, button, hold_delay_ms,
		input ready);
	modport sink (input valid, func, now_ms, raw_levels, button, hold_delay_ms,
		output ready);
endinterface
`default_nettype wire

[hdl/bdch_out_if.sv]
`default_nettype none
interface bdch_out_if
	import bdch_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pressed_mask;
	logic              held;
	logic              clicked;

	modport source (output valid, pressed_mask, held, clicked, input ready);
	modport sink (input valid, pressed_mask, held, clicked, output ready);
endinterface
`default_nettype wire

[hdl/bdch_lane.sv]
`default_nettype none
module bdch_lane
	import bdch_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_cmd_t          cmd,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic               level_in,
	input  wire logic [DELAY_W-1:0] hold_delay_ms,
	input  wire logic [CFG_W-1:0]   debounce_min_ms,
	input  wire logic [CFG_W-1:0]   click_max_ms,
	output lane_res_t               res
);

	logic              stable_q;
	logic [TIME_W-1:0] change_time_q;
	logic              pending_q;
	logic              locked_q;

	logic [TIME_W-1:0] elapsed;
	logic              debounce_over;
	logic              click_short;
	logic              hold_over;
	logic              change;
	logic              hold_fire;
	logic              click_fire;

	// elapsed time wraps modulo 2^32
	assign elapsed       = now_ms - change_time_q;
	assign debounce_over = elapsed > TIME_W'(debounce_min_ms);
	assign click_short   = elapsed < TIME_W'(click_max_ms);
	assign hold_over     = elapsed > TIME_W'(hold_delay_ms);

	assign change     = cmd.do_poll && (level_in != stable_q) && debounce_over;
	assign hold_fire  = cmd.do_hold && hold_over && stable_q && !locked_q;
	assign click_fire = cmd.do_click && pending_q && !locked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			change_time_q <= '0;
			pending_q     <= 1'b0;
			locked_q      <= 1'b0;
		end else begin
			if (change) begin
				stable_q      <= level_in;
				change_time_q <= now_ms;
				if (!level_in) begin
					locked_q <= 1'b0;
					if (click_short) begin
						pending_q <= 1'b1;
					end
				end else begin
					pending_q <= 1'b0;
				end
			end
			if (hold_fire) begin
				locked_q <= 1'b1;
			end
			if (click_fire) begin
				pending_q <= 1'b0;
			end
		end
	end

	// level after the step
	assign res.level   = change ? level_in : stable_q;
	assign res.held    = hold_fire;
	assign res.clicked = click_fire;

endmodule
`default_nettype wire

[hdl/bdch_merge.sv]
`default_nettype none
module bdch_merge
	import bdch_pkg::*;
#(
	parameter int LANE_COUNT = 4
) (
	input  wire lane_res_t lane_res [LANE_COUNT],
	output result_t        merged
);

	logic [LANE_COUNT-1:0] held_vec;
	logic [LANE_COUNT-1:0] clicked_vec;

	for (genvar i = 0; i < LANE_COUNT; i++) begin : g_vec
		assign held_vec[i]    = lane_res[i].held;
		assign clicked_vec[i] = lane_res[i].clicked;
	end

	// only the first buttons fit the mask
	for (genvar j = 0; j < MASK_W; j++) begin : g_mask
		if (j < LANE_COUNT) begin : g_used
			assign merged.pressed_mask[j] = lane_res[j].level;
		end else begin : g_none
			assign merged.pressed_mask[j] = 1'b0;
		end
	end

	assign merged.held    = |held_vec;
	assign merged.clicked = |clicked_vec;

endmodule
`default_nettype wire

[hdl/button_debounce_click_hold_core.sv]
`default_nettype none
// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------------
// item     | in  | valid / ready | func, now_ms, raw_levels, button, hold_delay_ms
// result   | out | valid / ready | pressed_mask, held, clicked
// apb      | in  | psel/penable  | paddr, pwdata -> prdata, pready always high
//
// one item per cycle while the skid slot is free: every button lane updates its state at the transfer edge,
// the merged result is registered into the output register, or into the skid slot on a result stall
// the lane's 32-bit elapsed-time subtract plus its compares set the cycle time
// a two-entry output register and skid slot take the item stream across result stalls;
// item.ready drops only when both are full
// arst_n clears lane state, output valids and config to 50 ms debounce, 300 ms click
module button_debounce_click_hold_core
	import bdch_pkg::*;
#(
	parameter int BUTTON_COUNT = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	bdch_in_if.sink                item,
	bdch_out_if.source             result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	// configuration registers
	logic [CFG_W-1:0] debounce_min_q;
	logic [CFG_W-1:0] click_max_q;
	logic             cfg_write;
	reg_idx_t         reg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	// registers are word aligned, the low address bits are ignored
	assign reg_idx   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_min_q <= DEBOUNCE_RESET;
			click_max_q    <= CLICK_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_DEBOUNCE: debounce_min_q <= pwdata[CFG_W-1:0];
				REG_CLICK:    click_max_q    <= pwdata[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = APB_DW'(debounce_min_q);
			REG_CLICK:    prdata = APB_DW'(click_max_q);
			default:      prdata = '0;
		endcase
	end

	// item transfer and operation decode
	logic in_xfer;
	logic is_poll;
	logic is_hold;
	logic is_click;

	assign in_xfer = item.valid && item.ready;

	always_comb begin
		is_poll  = 1'b0;
		is_hold  = 1'b0;
		is_click = 1'b0;
		unique case (item.func)
			FUNC_POLL:  is_poll  = 1'b1;
			FUNC_HOLD:  is_hold  = 1'b1;
			FUNC_CLICK: is_click = 1'b1;
			default:    ;
		endcase
	end

	// one lane per button
	lane_res_t lane_res [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] lane_held;

	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
		logic      level;
		logic      sel;
		lane_cmd_t cmd;

		// buttons past the raw input width read released and cannot be queried
		if (i < RAW_W) begin : g_io
			assign level = item.raw_levels[i];
			assign sel   = (item.button == BTN_W'(i));
		end else begin : g_noio
			assign level = 1'b0;
			assign sel   = 1'b0;
		end

		assign cmd.do_poll  = in_xfer && is_poll;
		assign cmd.do_hold  = in_xfer && is_hold && sel;
		assign cmd.do_click = in_xfer && is_click && sel;

		bdch_lane u_lane (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmd            (cmd),
			.now_ms         (item.now_ms),
			.level_in       (level),
			.hold_delay_ms  (item.hold_delay_ms),
			.debounce_min_ms(debounce_min_q),
			.click_max_ms   (click_max_q),
			.res            (lane_res[i])
		);

		assign lane_held[i] = lane_res[i].held;
	end

	result_t merged;

	bdch_merge #(
		.LANE_COUNT(BUTTON_COUNT)
	) u_merge (
		.lane_res(lane_res),
		.merged  (merged)
	);

	// output register plus skid slot
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    out_xfer;
	logic    out_free;

	assign item.ready = !skid_valid_q;
	assign out_xfer   = out_valid_q && result.ready;
	assign out_free   = out_xfer || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// the skid slot holds the older result, so it drains first
				out_valid_q  <= skid_valid_q || in_xfer;
				skid_valid_q <= 1'b0;
			end else if (in_xfer) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : merged;
		end
		if (!out_free && in_xfer) begin
			skid_data_q <= merged;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pressed_mask = out_data_q.pressed_mask;
	assign result.held         = out_data_q.held;
	assign result.clicked      = out_data_q.clicked;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full while output register empty");

	a_one_hold_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_held))
		else $error("hold fired in more than one lane");

	a_held_xor_clicked: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.held && result.clicked))
		else $error("result reports hold and click together");

	a_full_blocks_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready && in_xfer) |=> skid_valid_q)
		else $error("stalled transfer not caught by skid slot");

endmodule
`default_nettype wire

[bench/button_debounce_click_hold_core_test.sv]
`timescale 1ns / 100ps

// drives polls, hold queries and click queries into the debouncer core, predicts each
// report with a cycle-free copy of the per-button state and checks every result transfer
// against the oldest outstanding prediction
module button_debounce_click_hold_core_test
	import bdch_pkg::*;
;

	localparam int NBTN = 4;
	localparam int IDLE_LIMIT = 2000;
	// the fourth operation code has no meaning: the core answers it without any change
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	bdch_in_if  item_ch ();
	bdch_out_if result_ch ();

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	button_debounce_click_hold_core #(
		.BUTTON_COUNT(NBTN)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 20 ns period, first rising edge at 10 ns
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// debounced state of each button as the core should hold it
	logic [NBTN-1:0] dbn_level    = '0;
	logic [31:0]     dbn_since [NBTN] = '{default: '0};
	logic [NBTN-1:0] click_armed  = '0;
	logic [NBTN-1:0] hold_latched = '0;
	logic [CFG_W-1:0] cfg_debounce = DEBOUNCE_RESET;
	logic [CFG_W-1:0] cfg_click    = CLICK_RESET;

	// reports still owed by the core, oldest first
	result_t expected_reports [$];

	int mismatches     = 0;
	int items_accepted = 0;
	int reports_seen   = 0;
	int holds_seen     = 0;
	int clicks_seen    = 0;
	int cfg_writes     = 0;
	int phases         = 0;
	int idle_cycles    = 0;

	// sender burst shaping
	int burst_left  = 0;
	bit sender_gaps = 1'b1;

	// random traffic time base and the levels a well-behaved user is holding
	logic [31:0]     sim_ms = '0;
	logic [NBTN-1:0] target = '0;

	// one item applied to the debounce state, returns the report it causes
	function automatic result_t predict_buttons(input logic [FUNC_W-1:0] op,
			input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw,
			input logic [BTN_W-1:0] btn, input logic [DELAY_W-1:0] delay);
		result_t r;
		logic [31:0] elapsed;
		r = '0;
		case (op)
			FUNC_POLL: begin
				for (int i = 0; i < NBTN; i++) begin
					// elapsed time wraps, so an older stamp reads as a long time
					elapsed = now - dbn_since[i];
					if (raw[i] != dbn_level[i] && elapsed > cfg_debounce) begin
						if (!raw[i]) begin
							hold_latched[i] = 1'b0;
							if (elapsed < cfg_click)
								click_armed[i] = 1'b1;
						end else begin
							click_armed[i] = 1'b0;
						end
						dbn_level[i] = raw[i];
						dbn_since[i] = now;
					end
				end
			end
			FUNC_HOLD: begin
				elapsed = now - dbn_since[btn];
				// fires once per press, then stays quiet until the release
				if (elapsed > delay && dbn_level[btn] && !hold_latched[btn]) begin
					hold_latched[btn] = 1'b1;
					r.held = 1'b1;
				end
			end
			FUNC_CLICK: begin
				if (click_armed[btn] && !hold_latched[btn]) begin
					click_armed[btn] = 1'b0;
					r.clicked = 1'b1;
				end
			end
			default: ;
		endcase
		r.pressed_mask = dbn_level;
		return r;
	endfunction

	// result side: stall pattern that changes each time the 6-bit phase counter wraps,
	// half of the windows have no stall at all
	logic [5:0] stall_phase = '0;
	int         stall_len   = 0;

	always @(negedge clk) begin
		stall_phase <= stall_phase + 6'd1;
		if (stall_phase == '1)
			stall_len <= $urandom_range(0, 1) ? int'($urandom_range(1, 6)) : 0;
		result_ch.ready <= (stall_phase % 11) >= stall_len;
	end

	// both channels are observed at the rising edge: an accepted item is predicted
	// first, then a result transfer is checked against the oldest prediction
	result_t want;
	result_t got;
	bit      busy;

	always @(posedge clk) begin
		if (arst_n) begin
			busy = 1'b0;
			if (item_ch.valid && item_ch.ready) begin
				expected_reports.push_back(predict_buttons(item_ch.func, item_ch.now_ms,
					item_ch.raw_levels, item_ch.button, item_ch.hold_delay_ms));
				items_accepted++;
				busy = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				busy = 1'b1;
				got.pressed_mask = result_ch.pressed_mask;
				got.held         = result_ch.held;
				got.clicked      = result_ch.clicked;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: mask %h held %b clicked %b",
							got.pressed_mask, got.held, got.clicked);
				end else begin
					want = expected_reports.pop_front();
					reports_seen++;
					holds_seen  += got.held;
					clicks_seen += got.clicked;
					if (got.pressed_mask !== want.pressed_mask || got.held !== want.held ||
							got.clicked !== want.clicked) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: want %h/%b/%b, got %h/%b/%b",
								reports_seen, want.pressed_mask, want.held, want.clicked,
								got.pressed_mask, got.held, got.clicked);
					end
				end
			end
			if (psel && penable && pready)
				busy = 1'b1;
			idle_cycles = busy ? 0 : idle_cycles + 1;
		end
	end

	// watchdog: a long run of cycles with no transfer anywhere means a hang
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("no transfer for %0d cycles, %0d reports outstanding", IDLE_LIMIT,
			expected_reports.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// one item on the input channel; entered and left at a falling edge, valid stays
	// high afterwards so that back-to-back items need no extra assignment
	task automatic send_item(input logic [FUNC_W-1:0] op, input logic [TIME_W-1:0] now,
			input logic [RAW_W-1:0] raw, input logic [BTN_W-1:0] btn,
			input logic [DELAY_W-1:0] delay);
		if (burst_left <= 0) begin
			if (sender_gaps) begin
				item_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		item_ch.valid         <= 1'b1;
		item_ch.func          <= op;
		item_ch.now_ms        <= now;
		item_ch.raw_levels    <= raw;
		item_ch.button        <= btn;
		item_ch.hold_delay_ms <= delay;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// sender holds off until every outstanding report has come back
	task automatic wait_results_drained();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (expected_reports.size() != 0)
			@(negedge clk);
		// let the result register settle after the last transfer
		repeat (2) @(negedge clk);
	endtask

	// one apb transfer: setup phase, then access phase until pready, then an idle phase
	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd[CFG_W-1:0] !== value) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %s reads %h, expected %h", idx.name(), rd[CFG_W-1:0], value);
		end
	endtask

	// write, mirror into the predictor, read back
	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, idx, APB_DW'(value), rd);
		case (idx)
			REG_DEBOUNCE: cfg_debounce = value;
			REG_CLICK:    cfg_click    = value;
		endcase
		cfg_writes++;
		check_reg(idx, value);
	endtask

	task automatic test_register_readback();
		check_reg(REG_DEBOUNCE, DEBOUNCE_RESET);
		check_reg(REG_CLICK, CLICK_RESET);
	endtask

	// hand-picked sequence under the reset timing of 50 ms debounce, 300 ms click
	task automatic test_directed_cases();
		send_item(FUNC_POLL, 32'd0, 4'h0, 2'd0, 15'd0);
		// exactly the debounce time is not enough, one more ms is
		send_item(FUNC_POLL, 32'd50, 4'hF, 2'd0, 15'd0);
		send_item(FUNC_POLL, 32'd51, 4'hF, 2'd0, 15'd0);
		// zero hold delay: needs at least one ms of press, then fires only once
		send_item(FUNC_HOLD, 32'd51, 4'h0, 2'd0, 15'd0);
		send_item(FUNC_HOLD, 32'd52, 4'h0, 2'd0, 15'd0);
		send_item(FUNC_HOLD, 32'd53, 4'h0, 2'd0, 15'd0);
		// short press of button 0 makes a click, which is consumed once
		send_item(FUNC_POLL, 32'd120, 4'hE, 2'd0, 15'd0);
		send_item(FUNC_CLICK, 32'd121, 4'h0, 2'd0, 15'd0);
		send_item(FUNC_CLICK, 32'd122, 4'h0, 2'd0, 15'd0);
		send_item(FUNC_CLICK, 32'd122, 4'h0, 2'd1, 15'd0);
		// release one ms under the click limit and exactly at it
		send_item(FUNC_POLL, 32'd350, 4'hC, 2'd1, 15'd0);
		send_item(FUNC_POLL, 32'd351, 4'h8, 2'd2, 15'd0);
		send_item(FUNC_CLICK, 32'd352, 4'h0, 2'd2, 15'd0);
		send_item(FUNC_CLICK, 32'd353, 4'h0, 2'd1, 15'd0);
		// unused operation with every field at its top value
		send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 4'hF, 2'd3, 15'h7FFF);
		// a stamp that wraps past zero still gives the short elapsed time across the wrap
		send_item(FUNC_POLL, 32'hFFFF_FFF0, 4'h0, 2'd3, 15'h7FFF);
		send_item(FUNC_POLL, 32'd10, 4'h8, 2'd3, 15'h7FFF);
		send_item(FUNC_POLL, 32'd100, 4'h8, 2'd3, 15'h7FFF);
		// longest hold delay, on the edge and one ms past it
		send_item(FUNC_HOLD, 32'd32867, 4'h0, 2'd3, 15'h7FFF);
		send_item(FUNC_HOLD, 32'd32868, 4'h0, 2'd3, 15'h7FFF);
		// long press release: no click, hold lock cleared, released button never holds
		send_item(FUNC_POLL, 32'd32900, 4'h0, 2'd3, 15'h7FFF);
		send_item(FUNC_HOLD, 32'd40000, 4'h0, 2'd3, 15'd0);
		send_item(FUNC_CLICK, 32'd40001, 4'h0, 2'd3, 15'd0);
		send_item(FUNC_POLL, 32'hFFFF_FFFF, 4'hF, 2'd0, 15'd0);
	endtask

	// time advance scaled to the current setting: mostly bounce-sized or
	// press-sized steps, now and then a jump anywhere in the 32-bit range
	function automatic logic [31:0] time_step();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return $urandom_range(0, cfg_debounce / 2 + 3);
		else if (pick < 85)
			return $urandom_range(cfg_debounce, cfg_debounce + cfg_click + 10);
		else if (pick < 97)
			return $urandom_range(0, 40000);
		return $urandom;
	endfunction

	// mostly polls that follow a user's intended levels with occasional bounce,
	// mixed with hold and click queries and a few unused codes
	task automatic random_item();
		int unsigned       pick;
		logic [FUNC_W-1:0] op;
		logic [RAW_W-1:0]  raw;
		logic [BTN_W-1:0]  btn;
		logic [DELAY_W-1:0] delay;
		pick  = $urandom_range(0, 99);
		sim_ms = sim_ms + time_step();
		raw   = RAW_W'($urandom);
		btn   = BTN_W'($urandom);
		delay = $urandom_range(0, 3) == 0 ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 600));
		if (pick < 55) begin
			op = FUNC_POLL;
			if ($urandom_range(0, 9) < 3)
				target[$urandom_range(0, NBTN - 1)] ^= 1'b1;
			// one poll in ten is contact noise
			if ($urandom_range(0, 9) != 0)
				raw = target;
		end else if (pick < 75) begin
			op = FUNC_HOLD;
		end else if (pick < 95) begin
			op = FUNC_CLICK;
		end else begin
			op = FUNC_UNUSED;
		end
		send_item(op, sim_ms, raw, btn, delay);
	endtask

	// one timing setting, written while the core is idle, then random traffic
	task automatic test_random_traffic(input logic [CFG_W-1:0] debounce_ms,
			input logic [CFG_W-1:0] click_ms, input int n_items, input bit gaps);
		wait_results_drained();
		cfg_write(REG_DEBOUNCE, debounce_ms);
		cfg_write(REG_CLICK, click_ms);
		sender_gaps = gaps;
		for (int k = 0; k < n_items; k++) begin
			// halfway through, let the result side empty completely
			if (k == n_items / 2)
				wait_results_drained();
			random_item();
		end
		phases++;
	endtask

	initial begin
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.func          = FUNC_POLL;
		item_ch.now_ms        = '0;
		item_ch.raw_levels    = '0;
		item_ch.button        = '0;
		item_ch.hold_delay_ms = '0;
		result_ch.ready       = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_register_readback();
		test_directed_cases();
		test_random_traffic(DEBOUNCE_RESET, CLICK_RESET, 255, 1'b1);
		// zero debounce and zero click window, sender never idles
		test_random_traffic(16'd0, 16'd0, 255, 1'b0);
		test_random_traffic(16'hFFFF, 16'hFFFF, 255, 1'b1);
		test_random_traffic(16'd10, 16'hFFFF, 255, 1'b1);
		test_random_traffic(16'hFFFF, 16'd0, 255, 1'b0);
		test_random_traffic(CFG_W'($urandom_range(1, 400)), CFG_W'($urandom_range(1, 2000)),
			255, 1'b1);

		wait_results_drained();
		repeat (8) @(negedge clk);
		if (expected_reports.size() != 0) begin
			mismatches++;
			$display("%0d reports never arrived", expected_reports.size());
		end

		$display("ran directed cases and %0d timing settings: %0d items, %0d reports checked",
			phases, items_accepted, reports_seen);
		$display("holds reported %0d, clicks consumed %0d, register writes %0d, mismatches %0d",
			holds_seen, clicks_seen, cfg_writes, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
